/* rtl/core/lofq_pkg.sv */
// Shared types and constants of the lossy outbound frame queue.
`default_nettype none

package lofq_pkg;

  // Register file geometry and reset values.
  localparam int unsigned CfgAddrW      = 3;
  localparam int unsigned CfgDataW      = 32;
  localparam int unsigned MaxFramesW    = 11;
  localparam int unsigned MaxBytesW     = 20;
  localparam int unsigned DroppedW      = 11;
  localparam int unsigned QueuedFramesW = 11;

  localparam logic [MaxFramesW-1:0] MaxFramesRst = MaxFramesW'(1024);
  localparam logic [MaxBytesW-1:0]  MaxBytesRst  = MaxBytesW'(512 * 1024);
  localparam logic [DroppedW-1:0]   DroppedSat   = '1;

  // Register indexes, taken from the word address.
  localparam logic RegMaxFrames = 1'b0;
  localparam logic RegMaxBytes  = 1'b1;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_ENQUEUE    = 2'd0,
    OP_SEND_OK    = 2'd1,
    OP_SEND_FAIL  = 2'd2,
    OP_RESERVED   = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_ZERO_LEN  = 2'd1,
    STAT_OVERSIZE  = 2'd2,
    STAT_NO_SEND   = 2'd3
  } status_e;

  // Controller sequencing states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Budget registers as seen by the controller.
  typedef struct packed {
    logic [MaxFramesW-1:0] max_frames;
    logic [MaxBytesW-1:0]  max_bytes;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/lofq_if.sv */
// Request and result channel interfaces of the lossy outbound frame queue.
`default_nettype none

interface lofq_req_if #(
  parameter int unsigned TAG_BITS = 16,
  parameter int unsigned LEN_BITS = 20
);
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [TAG_BITS-1:0] frame_tag;
  logic [LEN_BITS-1:0] frame_size;

  modport source (output valid, op, frame_tag, frame_size, input ready);
  modport sink   (input valid, op, frame_tag, frame_size, output ready);
endinterface

interface lofq_rsp_if #(
  parameter int unsigned TAG_BITS = 16,
  parameter int unsigned LEN_BITS = 20
);
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [10:0]         dropped_count;
  logic                send_start;
  logic [TAG_BITS-1:0] send_tag;
  logic [LEN_BITS-1:0] send_len;
  logic [10:0]         queued_frames;
  logic [LEN_BITS:0]   queued_bytes;

  modport source (output valid, status, dropped_count, send_start, send_tag, send_len,
                  queued_frames, queued_bytes, input ready);
  modport sink   (input valid, status, dropped_count, send_start, send_tag, send_len,
                  queued_frames, queued_bytes, output ready);
endinterface

`default_nettype wire

/* rtl/core/lofq_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module lofq_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // A read of the address written in the same cycle returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/core/lofq_cfg.sv */
// APB-style budget register file of the lossy outbound frame queue.
`default_nettype none

module lofq_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lofq_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [lofq_pkg::CfgDataW-1:0]  pwdata,
  output logic      [lofq_pkg::CfgDataW-1:0]  prdata,
  output logic                                pready,
  output lofq_pkg::cfg_t                      cfg_o
);
  import lofq_pkg::*;

  logic [MaxFramesW-1:0] max_frames_q;
  logic [MaxBytesW-1:0]  max_bytes_q;
  logic                  wr_en;
  logic                  reg_idx;

  // Registers are word aligned; the word address selects the register.
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frames_q <= MaxFramesRst;
      max_bytes_q  <= MaxBytesRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegMaxFrames: max_frames_q <= pwdata[MaxFramesW-1:0];
        RegMaxBytes:  max_bytes_q  <= pwdata[MaxBytesW-1:0];
        default:      ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      RegMaxFrames: prdata = CfgDataW'(max_frames_q);
      RegMaxBytes:  prdata = CfgDataW'(max_bytes_q);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o.max_frames = max_frames_q;
  assign cfg_o.max_bytes  = max_bytes_q;

endmodule

`default_nettype wire

/* rtl/core/lofq_ctrl.sv */
// Queue controller: request sequencing, ring pointers, budgets and result register.
`default_nettype none

module lofq_ctrl #(
  parameter int unsigned DEPTH    = 1024,
  parameter int unsigned LEN_BITS = 20,
  parameter int unsigned TAG_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lofq_pkg::cfg_t                cfg_i,
  lofq_req_if.sink                           req,
  lofq_rsp_if.source                         rsp,
  output logic                               ram_we_o,
  output logic [$clog2(DEPTH)-1:0]           ram_waddr_o,
  output logic [TAG_BITS+LEN_BITS-1:0]       ram_wdata_o,
  output logic [$clog2(DEPTH)-1:0]           ram_raddr_o,
  input  wire logic [TAG_BITS+LEN_BITS-1:0]  ram_rdata_i
);
  import lofq_pkg::*;

  localparam int unsigned PW  = $clog2(DEPTH);
  localparam int unsigned WCW = $clog2(DEPTH + 1);
  localparam int unsigned CW0 = $clog2(DEPTH + 2);
  localparam int unsigned CW  = (CW0 > MaxFramesW) ? CW0 : MaxFramesW;
  localparam int unsigned BW  = ((LEN_BITS > MaxBytesW) ? LEN_BITS : MaxBytesW) + 1;
  localparam int unsigned SW  = BW + 1;
  localparam int unsigned DW  = TAG_BITS + LEN_BITS;

  // Sequencer and request registers.
  state_e              state_q, state_d;
  op_e                 op_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [LEN_BITS-1:0] len_q;
  logic [DroppedW-1:0] drop_q, drop_d;

  // Queue state.
  logic [PW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [PW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [WCW-1:0]      wc_q, wc_d;
  logic [CW-1:0]       held_cnt_q, held_cnt_d;
  logic [BW-1:0]       held_bytes_q, held_bytes_d;
  logic                in_flight_q, in_flight_d;
  logic [TAG_BITS-1:0] fl_tag_q, fl_tag_d;
  logic [LEN_BITS-1:0] fl_len_q, fl_len_d;

  // Head-of-ring forwarding.
  logic                fwd_valid_q;
  logic [DW-1:0]       fwd_data_q;
  logic [DW-1:0]       head;
  logic [TAG_BITS-1:0] head_tag;
  logic [LEN_BITS-1:0] head_len;

  // Result register.
  logic                out_valid_q, out_valid_d;
  status_e             status_q, status_d;
  logic [DroppedW-1:0] dropped_q;
  logic                start_q, start_d;
  logic [TAG_BITS-1:0] stag_q, stag_d;
  logic [LEN_BITS-1:0] slen_q, slen_d;
  logic [QueuedFramesW-1:0] qf_q;
  logic [LEN_BITS:0]   qb_q;

  logic                accept;
  logic                out_free;
  logic                fin;
  logic                over;
  logic [SW-1:0]       byte_sum;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  // The RAM reads the next head every cycle; a write to that entry is forwarded.
  assign head     = fwd_valid_q ? fwd_data_q : ram_rdata_i;
  assign head_tag = head[DW-1:LEN_BITS];
  assign head_len = head[LEN_BITS-1:0];

  assign req.ready = (state_q == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid_q || rsp.ready;

  // Budget check for an enqueue against what is held now.
  assign byte_sum = SW'(held_bytes_q) + SW'(len_q);
  assign over = (held_cnt_q >= CW'(cfg_i.max_frames)) ||
                (byte_sum > SW'(cfg_i.max_bytes)) ||
                (wc_q == WCW'(DEPTH));

  // Next state, queue updates and result.
  always_comb begin
    state_d      = state_q;
    drop_d       = drop_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    wc_d         = wc_q;
    held_cnt_d   = held_cnt_q;
    held_bytes_d = held_bytes_q;
    in_flight_d  = in_flight_q;
    fl_tag_d     = fl_tag_q;
    fl_len_d     = fl_len_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = wr_ptr_q;
    ram_wdata_o  = {tag_q, len_q};
    fin          = 1'b0;
    status_d     = STAT_OK;
    start_d      = 1'b0;
    stag_d       = '0;
    slen_d       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          drop_d  = '0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_q)
          OP_ENQUEUE: begin
            if (len_q == '0) begin
              fin      = out_free;
              status_d = STAT_ZERO_LEN;
            end else if (BW'(len_q) > BW'(cfg_i.max_bytes)) begin
              fin      = out_free;
              status_d = STAT_OVERSIZE;
            end else if (over && (wc_q != '0)) begin
              // Drop the oldest waiting frame, one per cycle.
              held_bytes_d = held_bytes_q - BW'(head_len);
              held_cnt_d   = held_cnt_q - CW'(1);
              wc_d         = wc_q - WCW'(1);
              rd_ptr_d     = ring_next(rd_ptr_q);
              drop_d       = (drop_q == DroppedSat) ? drop_q : drop_q + DroppedW'(1);
            end else if (out_free) begin
              // Append the frame, and start it or the head if the link is idle.
              fin          = 1'b1;
              ram_we_o     = 1'b1;
              wr_ptr_d     = ring_next(wr_ptr_q);
              held_cnt_d   = held_cnt_q + CW'(1);
              held_bytes_d = held_bytes_q + BW'(len_q);
              if (!in_flight_q) begin
                in_flight_d = 1'b1;
                rd_ptr_d    = ring_next(rd_ptr_q);
                start_d     = 1'b1;
                if (wc_q == '0) begin
                  fl_tag_d = tag_q;
                  fl_len_d = len_q;
                end else begin
                  fl_tag_d = head_tag;
                  fl_len_d = head_len;
                end
                stag_d = fl_tag_d;
                slen_d = fl_len_d;
              end else begin
                wc_d = wc_q + WCW'(1);
              end
            end
          end
          OP_SEND_OK: begin
            if (out_free) begin
              fin = 1'b1;
              if (!in_flight_q) begin
                status_d = STAT_NO_SEND;
              end else begin
                held_cnt_d   = held_cnt_q - CW'(1);
                held_bytes_d = held_bytes_q - BW'(fl_len_q);
                if (wc_q != '0) begin
                  // Hand the oldest waiting frame to the transport.
                  fl_tag_d = head_tag;
                  fl_len_d = head_len;
                  rd_ptr_d = ring_next(rd_ptr_q);
                  wc_d     = wc_q - WCW'(1);
                  start_d  = 1'b1;
                  stag_d   = head_tag;
                  slen_d   = head_len;
                end else begin
                  in_flight_d = 1'b0;
                  fl_tag_d    = '0;
                  fl_len_d    = '0;
                end
              end
            end
          end
          OP_SEND_FAIL: begin
            if (out_free) begin
              fin          = 1'b1;
              rd_ptr_d     = '0;
              wr_ptr_d     = '0;
              wc_d         = '0;
              held_cnt_d   = '0;
              held_bytes_d = '0;
              in_flight_d  = 1'b0;
              fl_tag_d     = '0;
              fl_len_d     = '0;
            end
          end
          OP_RESERVED: begin
            fin = out_free;
          end
        endcase
        if (fin) begin
          state_d = S_IDLE;
        end
      end
    endcase

    out_valid_d = fin ? 1'b1 : (out_valid_q && !rsp.ready);
  end

  assign ram_raddr_o = rd_ptr_d;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      wc_q         <= '0;
      held_cnt_q   <= '0;
      held_bytes_q <= '0;
      in_flight_q  <= 1'b0;
      fl_tag_q     <= '0;
      fl_len_q     <= '0;
      out_valid_q  <= 1'b0;
      fwd_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_ptr_q     <= rd_ptr_d;
      wr_ptr_q     <= wr_ptr_d;
      wc_q         <= wc_d;
      held_cnt_q   <= held_cnt_d;
      held_bytes_q <= held_bytes_d;
      in_flight_q  <= in_flight_d;
      fl_tag_q     <= fl_tag_d;
      fl_len_q     <= fl_len_d;
      out_valid_q  <= out_valid_d;
      fwd_valid_q  <= ram_we_o && (ram_waddr_o == rd_ptr_d);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    fwd_data_q <= ram_wdata_o;
    drop_q     <= drop_d;
    if (accept) begin
      op_q  <= op_e'(req.op);
      tag_q <= req.frame_tag;
      len_q <= req.frame_size;
    end
    if (fin) begin
      status_q  <= status_d;
      dropped_q <= drop_q;
      start_q   <= start_d;
      stag_q    <= stag_d;
      slen_q    <= slen_d;
      qf_q      <= held_cnt_d[QueuedFramesW-1:0];
      qb_q      <= held_bytes_d[LEN_BITS:0];
    end
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.status        = status_q;
  assign rsp.dropped_count = dropped_q;
  assign rsp.send_start    = start_q;
  assign rsp.send_tag      = stag_q;
  assign rsp.send_len      = slen_q;
  assign rsp.queued_frames = qf_q;
  assign rsp.queued_bytes  = qb_q;

  // The held count always equals the waiting frames plus the one in flight.
  a_held_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q == CW'(wc_q) + CW'(in_flight_q))
    else $error("held frame count out of step with ring count");

  // Frames only wait while a send is in flight.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_flight_q |-> (wc_q == '0))
    else $error("frames waiting while the link is idle");

  // The ring never holds more than its depth.
  a_ring_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wc_q <= WCW'(DEPTH))
    else $error("ring count exceeds depth");

  // A pending result that started a send implies a frame is in flight.
  a_start_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && start_q) |-> in_flight_q)
    else $error("send start reported with nothing in flight");

endmodule

`default_nettype wire

/* rtl/core/lossy_outbound_frame_queue_top.sv */
// Top level of the lossy outbound frame queue.
//
// Requests arrive on req_i (valid/ready): op 0 enqueues a frame descriptor
// (tag, length), op 1 reports a successful send, op 2 reports a failed send
// and empties the queue. Every request yields exactly one result on rsp_o
// (valid/ready) with the status, the number of waiting frames dropped, any
// send that starts now, and the frames and bytes held afterwards.
// The budgets max_frames and max_bytes sit behind an APB-style port at byte
// addresses 0 and 4; write them only while no request is in progress.
// A request is accepted, then executed; during execution the waiting frames to
// be dropped are discarded one at a time, since drops walk the descriptor ring
// through its single read port. The result is registered, so it appears the
// cycle after execution; the next request is accepted while it waits.
// If rsp_o stalls, a finished request holds in execute until the result
// register frees up; no result is lost. Reset empties the queue and loads
// the budgets 1024 frames and 524288 bytes; the ring needs no clearing.
`default_nettype none

module lossy_outbound_frame_queue_top #(
  parameter int unsigned DEPTH    = 1024,
  parameter int unsigned LEN_BITS = 20,
  parameter int unsigned TAG_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  lofq_req_if.sink                            req_i,
  lofq_rsp_if.source                          rsp_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lofq_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [lofq_pkg::CfgDataW-1:0]  pwdata,
  output logic      [lofq_pkg::CfgDataW-1:0]  prdata,
  output logic                                pready
);
  import lofq_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned DW = TAG_BITS + LEN_BITS;

  cfg_t          cfg;
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [PW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  // Budget registers.
  lofq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Descriptor ring: tag and length per waiting frame.
  lofq_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Request sequencing and queue bookkeeping.
  lofq_ctrl #(
    .DEPTH    (DEPTH),
    .LEN_BITS (LEN_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req         (req_i),
    .rsp         (rsp_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench of the lossy outbound frame queue with its own queue predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lofq_pkg::*;

  localparam int unsigned RingDepth = 1024;
  localparam int unsigned TagW      = 16;
  localparam int unsigned LenW      = 20;

  localparam logic [CfgAddrW-1:0] AddrMaxFrames = CfgAddrW'({RegMaxFrames, 2'b00});
  localparam logic [CfgAddrW-1:0] AddrMaxBytes  = CfgAddrW'({RegMaxBytes, 2'b00});

  // One predicted result of the queue.
  typedef struct {
    status_e                   status;
    logic [DroppedW-1:0]       dropped;
    logic                      send_start;
    logic [TagW-1:0]           send_tag;
    logic [LenW-1:0]           send_len;
    logic [QueuedFramesW-1:0]  frames;
    logic [LenW:0]             bytes;
  } queue_outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  lofq_req_if #(.TAG_BITS(TagW), .LEN_BITS(LenW)) req_ch ();
  lofq_rsp_if #(.TAG_BITS(TagW), .LEN_BITS(LenW)) rsp_ch ();

  lossy_outbound_frame_queue_top #(
    .DEPTH    (RingDepth),
    .LEN_BITS (LenW),
    .TAG_BITS (TagW)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  // Test control shared by the processes.
  bit             idling_on       = 1'b1;
  int             hold_off_cycles = 0;
  int             error_count     = 0;
  queue_outcome_t expected_outcomes[$];

  // Predictor state: budgets, waiting ring and the frame in flight.
  int unsigned     budget_frames = MaxFramesRst;
  int unsigned     budget_bytes  = MaxBytesRst;
  logic [TagW-1:0] ring_tag [RingDepth];
  logic [LenW-1:0] ring_len [RingDepth];
  int unsigned     rd_idx     = 0;
  int unsigned     wr_idx     = 0;
  int unsigned     wait_cnt   = 0;
  int unsigned     wait_bytes = 0;
  bit              flight_busy = 1'b0;
  logic [TagW-1:0] flight_tag_q = '0;
  logic [LenW-1:0] flight_len_q = '0;

  // Predictor: discard the oldest waiting frame.
  function automatic void drop_oldest();
    wait_bytes -= ring_len[rd_idx];
    wait_cnt--;
    rd_idx = (rd_idx + 1) % RingDepth;
  endfunction

  // Predictor: hand the oldest waiting frame to the link if it is idle.
  function automatic void start_next_send(inout queue_outcome_t r);
    if (!flight_busy && wait_cnt != 0) begin
      flight_tag_q = ring_tag[rd_idx];
      flight_len_q = ring_len[rd_idx];
      drop_oldest();
      flight_busy  = 1'b1;
      r.send_start = 1'b1;
      r.send_tag   = flight_tag_q;
      r.send_len   = flight_len_q;
    end
  endfunction

  // Predictor: true while the new frame does not fit the budgets or the ring.
  function automatic bit over_budget(logic [LenW-1:0] len);
    int unsigned held_cnt;
    longint unsigned held_bytes;
    held_cnt   = wait_cnt + (flight_busy ? 1 : 0);
    held_bytes = wait_bytes + (flight_busy ? flight_len_q : 0);
    return held_cnt >= budget_frames || held_bytes + len > budget_bytes ||
           wait_cnt >= RingDepth;
  endfunction

  // Predictor: apply one request and return the result it causes.
  function automatic queue_outcome_t predict_outcome(op_e op, logic [TagW-1:0] tag,
                                                     logic [LenW-1:0] len);
    queue_outcome_t r;
    r.status     = STAT_OK;
    r.dropped    = '0;
    r.send_start = 1'b0;
    r.send_tag   = '0;
    r.send_len   = '0;
    case (op)
      OP_ENQUEUE: begin
        if (len == 0) begin
          r.status = STAT_ZERO_LEN;
        end else if (len > budget_bytes) begin
          r.status = STAT_OVERSIZE;
        end else begin
          while (wait_cnt != 0 && over_budget(len)) begin
            drop_oldest();
            if (r.dropped != DroppedSat) r.dropped++;
          end
          ring_tag[wr_idx] = tag;
          ring_len[wr_idx] = len;
          wr_idx = (wr_idx + 1) % RingDepth;
          wait_cnt++;
          wait_bytes += len;
          start_next_send(r);
        end
      end
      OP_SEND_OK: begin
        if (!flight_busy) begin
          r.status = STAT_NO_SEND;
        end else begin
          flight_busy  = 1'b0;
          flight_tag_q = '0;
          flight_len_q = '0;
          start_next_send(r);
        end
      end
      OP_SEND_FAIL: begin
        rd_idx       = 0;
        wr_idx       = 0;
        wait_cnt     = 0;
        wait_bytes   = 0;
        flight_busy  = 1'b0;
        flight_tag_q = '0;
        flight_len_q = '0;
      end
      default: begin
      end
    endcase
    r.frames = QueuedFramesW'(wait_cnt + (flight_busy ? 1 : 0));
    r.bytes  = (LenW + 1)'(wait_bytes + (flight_busy ? flight_len_q : 0));
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin : outcome_check
    queue_outcome_t want;
    if (rst_ni === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (expected_outcomes.size() == 0) begin
        $error("result arrived with no request outstanding");
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        check_field("status", want.status, rsp_ch.status);
        check_field("dropped_count", want.dropped, rsp_ch.dropped_count);
        check_field("send_start", want.send_start, rsp_ch.send_start);
        check_field("send_tag", want.send_tag, rsp_ch.send_tag);
        check_field("send_len", want.send_len, rsp_ch.send_len);
        check_field("queued_frames", want.frames, rsp_ch.queued_frames);
        check_field("queued_bytes", want.bytes, rsp_ch.queued_bytes);
      end
    end
  end

  // Result ready: random stall bursts, and one long hold-off when asked for.
  initial begin : rsp_ready_gen
    rsp_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // Offer one request, wait for its acceptance and record the prediction.
  task automatic send_request(op_e op, logic [TagW-1:0] tag, logic [LenW-1:0] len);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.frame_tag  <= tag;
    req_ch.frame_size <= len;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    expected_outcomes.push_back(predict_outcome(op, tag, len));
  endtask

  // Random request with lengths spread around the current byte budget.
  task automatic send_random_request();
    int unsigned pick;
    int unsigned coarse;
    int unsigned fine;
    logic [LenW-1:0] len;
    coarse = (budget_bytes > 8) ? budget_bytes / 8 : 1;
    fine   = (budget_bytes > 64) ? budget_bytes / 64 : 1;
    case ($urandom_range(0, 15))
      0:          len = '0;
      1:          len = LenW'(budget_bytes + 1 + $urandom_range(0, 1000));
      2:          len = LenW'(budget_bytes);
      3:          len = LenW'($urandom);
      4, 5, 6, 7: len = LenW'($urandom_range(1, coarse));
      default:    len = LenW'($urandom_range(1, fine));
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 62)      send_request(OP_ENQUEUE, TagW'($urandom), len);
    else if (pick < 94) send_request(OP_SEND_OK, TagW'($urandom), len);
    else if (pick < 97) send_request(OP_SEND_FAIL, TagW'($urandom), len);
    else                send_request(OP_RESERVED, TagW'($urandom), len);
  endtask

  // Stop offering requests and let every outstanding result come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One APB transfer; the caller releases the bus after its last transfer.
  task automatic apb_xfer(bit write, logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] wdata,
                          output logic [CfgDataW-1:0] rdata);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdata = prdata;
      done  = pready;
      @(posedge clk_i);
    end while (!done);
  endtask

  task automatic check_budget_reg(string name, logic [CfgAddrW-1:0] addr, logic [31:0] want);
    logic [CfgDataW-1:0] got;
    apb_xfer(1'b0, addr, '0, got);
    check_field(name, want, got);
  endtask

  // Write both budgets while the queue is idle, then read them back.
  task automatic apply_budgets(int unsigned frames, int unsigned bytes);
    logic [CfgDataW-1:0] unused;
    wait_drained();
    apb_xfer(1'b1, AddrMaxFrames, frames, unused);
    apb_xfer(1'b1, AddrMaxBytes, bytes, unused);
    budget_frames = frames % (1 << MaxFramesW);
    budget_bytes  = bytes % (1 << MaxBytesW);
    check_budget_reg("max_frames register", AddrMaxFrames, budget_frames);
    check_budget_reg("max_bytes register", AddrMaxBytes, budget_bytes);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_register_reset();
    check_budget_reg("max_frames register", AddrMaxFrames, MaxFramesRst);
    check_budget_reg("max_bytes register", AddrMaxBytes, MaxBytesRst);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Field extremes, every operation and the named corner cases.
  task automatic test_directed_cases();
    send_request(OP_ENQUEUE, 16'h0000, 20'd1);
    send_request(OP_ENQUEUE, 16'hFFFF, LenW'(MaxBytesRst));
    send_request(OP_ENQUEUE, 16'h1234, 20'd0);
    send_request(OP_ENQUEUE, 16'h4321, LenW'(MaxBytesRst + 1));
    send_request(OP_ENQUEUE, 16'hFFFF, 20'hFFFFF);
    // Byte budget forces the waiting frame out, never the one in flight.
    send_request(OP_ENQUEUE, 16'hA5A5, 20'd100);
    send_request(OP_SEND_OK, 16'h0000, 20'd0);
    send_request(OP_SEND_OK, 16'h0000, 20'd0);
    // Completion with nothing in flight.
    send_request(OP_SEND_OK, 16'hFFFF, 20'hFFFFF);
    send_request(OP_RESERVED, 16'hFFFF, 20'hFFFFF);
    send_request(OP_ENQUEUE, 16'h0101, 20'd7);
    send_request(OP_ENQUEUE, 16'h0202, 20'd8);
    send_request(OP_ENQUEUE, 16'h0303, 20'd9);
    send_request(OP_SEND_FAIL, 16'hFFFF, 20'hFFFFF);
    send_request(OP_SEND_OK, 16'h0000, 20'd0);
    send_request(OP_ENQUEUE, 16'h5A5A, 20'd2);
    // A zero frame budget drops every waiting frame on each enqueue.
    apply_budgets(0, 20'hFFFFF);
    send_request(OP_ENQUEUE, 16'h0001, 20'hFFFFF);
    send_request(OP_ENQUEUE, 16'h0002, 20'd10);
    send_request(OP_ENQUEUE, 16'h0003, 20'd20);
    apply_budgets(1, 20'hFFFFF);
    send_request(OP_ENQUEUE, 16'h0004, 20'd30);
    send_request(OP_ENQUEUE, 16'h0005, 20'd40);
    send_request(OP_SEND_OK, 16'h0000, 20'd0);
    // A zero byte budget rejects every nonempty frame.
    apply_budgets(2047, 0);
    send_request(OP_ENQUEUE, 16'h0006, 20'd1);
    send_request(OP_ENQUEUE, 16'h0007, 20'd0);
    send_request(OP_SEND_FAIL, 16'h0000, 20'd0);
  endtask

  // A frame budget above the ring depth: the full ring drops the oldest frame.
  task automatic test_ring_full();
    apply_budgets(2047, 20'hFFFFF);
    send_request(OP_SEND_FAIL, '0, '0);
    repeat (RingDepth + 6) send_request(OP_ENQUEUE, TagW'($urandom), LenW'($urandom_range(1, 64)));
    repeat (3) send_request(OP_SEND_OK, '0, '0);
    send_request(OP_SEND_FAIL, '0, '0);
  endtask

  // The result side holds off for a long stretch while requests keep coming.
  task automatic test_long_stall();
    apply_budgets(8, MaxBytesRst);
    hold_off_cycles = 300;
    repeat (40) send_random_request();
  endtask

  // Random traffic over several budget settings; the last one runs without idling.
  task automatic test_random_budgets();
    int unsigned frames_set[8] = '{1024, 1, 2047, 4, 0, 16, 1024, 7};
    int unsigned bytes_set[8]  = '{524288, 1048575, 1048575, 300, 5000, 1, 64, 524288};
    for (int i = 0; i < 8; i++) begin
      apply_budgets(frames_set[i], bytes_set[i]);
      idling_on = (i != 7);
      repeat (90) send_random_request();
    end
  endtask

  initial begin : run_tests
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.op         <= OP_ENQUEUE;
    req_ch.frame_tag  <= '0;
    req_ch.frame_size <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_register_reset();
    test_directed_cases();
    test_ring_full();
    test_long_stall();
    test_random_budgets();
    wait_drained();
    if (error_count == 0) begin
      $display("** lossy_outbound_frame_queue_top: PASSED **");
    end else begin
      $display("** lossy_outbound_frame_queue_top: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #20_000_000;
    $display("** lossy_outbound_frame_queue_top: FAILED **");
    $finish;
  end

endmodule
